// File: rtl/core/pidlr_pkg.sv
// Shared constants for the PID light regulator: widths, gain format,
// configuration register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package pidlr_pkg;

    localparam int GAIN_FRAC_BITS = 16;

    localparam int LUX_W    = 16;
    localparam int ERR_W    = LUX_W + 1;     // target - measured
    localparam int DIFF_W   = ERR_W + 1;     // error - last error
    localparam int GAIN_W   = 32;
    localparam int SUM_W    = 32;
    localparam int SUMX_W   = SUM_W + 2;     // sum of three terms before saturation
    localparam int DUTY_W   = 16;
    localparam int TOTAL_W  = 64;
    localparam int DRIVE_W  = TOTAL_W - GAIN_FRAC_BITS;

    localparam int P_PROP_W = GAIN_W + ERR_W;
    localparam int P_INTG_W = GAIN_W + SUM_W;
    localparam int P_DERV_W = GAIN_W + DIFF_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERV_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY  = 2'd3;

    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST = 32'sd5833;
    localparam logic signed [GAIN_W-1:0] INTG_GAIN_RST = 32'sd492;
    localparam logic signed [GAIN_W-1:0] DERV_GAIN_RST = -32'sd3932;
    localparam logic [DUTY_W-1:0]        MAX_DUTY_RST  = 16'd999;

endpackage

// File: rtl/core/pid_light_regulator_top.sv
// PID light regulator top level: trapezoidal-integral PID on light samples.
// Depends on pidlr_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input stream (s_*): one beat per control tick, measured_lux in
//   s_tdata[15:0] and target_lux in s_tdata[31:16].
//   Result stream (m_*): one beat per input beat, duty_out in m_tdata[15:0],
//   clamped flag in m_tuser[0].
//   Config port: cfg_we/cfg_index/cfg_wdata write the three Q15.16 gains and
//   max_duty; write only while no beat is in flight.
//   Pipeline: an accepted beat passes the error/sum stage, the multiply stage
//   and the sum/clamp output register before m_tvalid rises.
//   Throughput: one beat per cycle unless back-pressure stalls the pipeline;
//   the three product multipliers set the stage depth. Integral and last
//   error update as each beat is accepted. Back-pressure: each stage holds
//   while the stage after it is full and stalled; empty stages still fill, so
//   s_tready drops only with all three stages full and m_tready low.
//   Reset (aresetn low, synchronous): pipeline emptied, integral and last
//   error cleared, registers back to their default values.

module pid_light_regulator_top
    import pidlr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,    // [15:0] measured_lux, [31:16] target_lux

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,    // [15:0] duty_out
    output logic [0:0]            m_tuser,    // [0] clamped

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration
    logic signed [GAIN_W-1:0] prop_gain_reg;
    logic signed [GAIN_W-1:0] intg_gain_reg;
    logic signed [GAIN_W-1:0] derv_gain_reg;
    logic [DUTY_W-1:0]        max_duty_reg;

    // controller state
    logic signed [SUM_W-1:0]  error_sum_reg, error_sum_next;
    logic signed [ERR_W-1:0]  last_error_reg;

    // stage 1: error, saturated sum, difference
    logic                     v1_reg;
    logic signed [ERR_W-1:0]  err1_reg, err_next;
    logic signed [SUM_W-1:0]  sum1_reg;
    logic signed [DIFF_W-1:0] diff1_reg, diff_next;

    // stage 2: products
    logic                       v2_reg;
    logic signed [P_PROP_W-1:0] pprop_reg, pprop_next;
    logic signed [P_INTG_W-1:0] pintg_reg, pintg_next;
    logic signed [P_DERV_W-1:0] pderv_reg, pderv_next;

    // output
    logic                     out_v_reg;
    logic [DUTY_W-1:0]        duty_reg, duty_next;
    logic                     clip_reg, clip_next;

    logic                     en_out, en2, en1, in_beat;
    logic signed [SUMX_W-1:0] sum_wide;
    logic signed [TOTAL_W-1:0] total;
    logic signed [DRIVE_W-1:0] drive;

    assign en_out   = !out_v_reg || m_tready;
    assign en2      = !v2_reg || en_out;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign in_beat  = s_tvalid && s_tready;

    // error and trapezoid sum from the incoming beat
    always_comb begin
        err_next = $signed({1'b0, s_tdata[2*LUX_W-1:LUX_W]})
                 - $signed({1'b0, s_tdata[LUX_W-1:0]});
        sum_wide = $signed({{(SUMX_W-SUM_W){error_sum_reg[SUM_W-1]}}, error_sum_reg})
                 + $signed({{(SUMX_W-ERR_W){err_next[ERR_W-1]}}, err_next})
                 + $signed({{(SUMX_W-ERR_W){last_error_reg[ERR_W-1]}}, last_error_reg});
        // saturate when the top bits disagree with the 32-bit sign
        if (sum_wide[SUMX_W-1:SUM_W-1] == '0 || sum_wide[SUMX_W-1:SUM_W-1] == '1) begin
            error_sum_next = sum_wide[SUM_W-1:0];
        end else if (sum_wide[SUMX_W-1]) begin
            error_sum_next = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            error_sum_next = {1'b0, {(SUM_W-1){1'b1}}};
        end
        diff_next = $signed({err_next[ERR_W-1], err_next})
                  - $signed({last_error_reg[ERR_W-1], last_error_reg});
    end

    always_comb begin
        pprop_next = $signed({{(P_PROP_W-GAIN_W){prop_gain_reg[GAIN_W-1]}}, prop_gain_reg})
                   * $signed({{(P_PROP_W-ERR_W){err1_reg[ERR_W-1]}}, err1_reg});
        pintg_next = $signed({{(P_INTG_W-GAIN_W){intg_gain_reg[GAIN_W-1]}}, intg_gain_reg})
                   * $signed({{(P_INTG_W-SUM_W){sum1_reg[SUM_W-1]}}, sum1_reg});
        pderv_next = $signed({{(P_DERV_W-GAIN_W){derv_gain_reg[GAIN_W-1]}}, derv_gain_reg})
                   * $signed({{(P_DERV_W-DIFF_W){diff1_reg[DIFF_W-1]}}, diff1_reg});
    end

    // sum of products, floor shift, clamp to 0..max_duty
    always_comb begin
        total = $signed({{(TOTAL_W-P_PROP_W){pprop_reg[P_PROP_W-1]}}, pprop_reg})
              + pintg_reg
              + $signed({{(TOTAL_W-P_DERV_W){pderv_reg[P_DERV_W-1]}}, pderv_reg});
        drive = total[TOTAL_W-1:GAIN_FRAC_BITS];
        if (drive[DRIVE_W-1]) begin
            duty_next = '0;
            clip_next = 1'b1;
        end else if (drive[DRIVE_W-1:DUTY_W] != '0 || drive[DUTY_W-1:0] > max_duty_reg) begin
            duty_next = max_duty_reg;
            clip_next = 1'b1;
        end else begin
            duty_next = drive[DUTY_W-1:0];
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= PROP_GAIN_RST;
            intg_gain_reg  <= INTG_GAIN_RST;
            derv_gain_reg  <= DERV_GAIN_RST;
            max_duty_reg   <= MAX_DUTY_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PROP_GAIN: prop_gain_reg <= cfg_wdata;
                REG_INTG_GAIN: intg_gain_reg <= cfg_wdata;
                REG_DERV_GAIN: derv_gain_reg <= cfg_wdata;
                REG_MAX_DUTY:  max_duty_reg  <= cfg_wdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            out_v_reg      <= 1'b0;
        end else begin
            if (in_beat) begin
                error_sum_reg  <= error_sum_next;
                last_error_reg <= err_next;
            end
            if (en1) begin
                v1_reg <= in_beat;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en_out) begin
                out_v_reg <= v2_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            err1_reg  <= err_next;
            sum1_reg  <= error_sum_next;
            diff1_reg <= diff_next;
        end
        if (en2 && v1_reg) begin
            pprop_reg <= pprop_next;
            pintg_reg <= pintg_next;
            pderv_reg <= pderv_next;
        end
        if (en_out && v2_reg) begin
            duty_reg <= duty_next;
            clip_reg <= clip_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = duty_reg;
    assign m_tuser  = clip_reg;

endmodule

// File: tb/pid_light_regulator_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for pid_light_regulator_top: directed and random light samples,
// a cycle-free PID predictor and a per-beat compare of duty and clamp flag.
// Depends on pidlr_pkg and the regulator RTL.

module pid_light_regulator_top_test;
    import pidlr_pkg::*;

    localparam logic signed [31:0] KP_DEFAULT   = 32'sd5833;
    localparam logic signed [31:0] KI_DEFAULT   = 32'sd492;
    localparam logic signed [31:0] KD_DEFAULT   = -32'sd3932;
    localparam logic [15:0]        DUTY_DEFAULT = 16'd999;
    localparam int                 LAT_CYCLES   = 3;
    localparam int                 DRAIN_LIMIT  = 2000;
    localparam int                 PHASE_BEATS  = 250;
    localparam int                 RAMP_BEATS   = 140;

    // packed MSB first, so measured lands in s_tdata[15:0]
    typedef struct packed {
        logic [15:0] target;
        logic [15:0] measured;
    } lux_sample_t;

    typedef struct {
        logic [15:0] duty;
        logic        clamped;
    } duty_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;     // [15:0] measured_lux, [31:16] target_lux
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;          // [15:0] duty_out
    logic [0:0]            m_tuser;          // [0] clamped
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    lux_sample_t  lux_samples[$];
    duty_result_t predicted_duty[$];
    int           mismatches = 0;
    int           queued_count = 0;
    int           accepted_count = 0;

    // register copies and loop state of the predictor
    logic signed [31:0] kp_q16 = KP_DEFAULT;
    logic signed [31:0] ki_q16 = KI_DEFAULT;
    logic signed [31:0] kd_q16 = KD_DEFAULT;
    logic [15:0]        duty_ceiling = DUTY_DEFAULT;
    logic signed [31:0] err_sum = '0;
    logic signed [16:0] prev_err = '0;

    int gap_left = 0;
    int tx_calm = 0;
    int stall_left = 0;
    int rx_calm = 0;

    pid_light_regulator_top i_dut (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns  %s", $time, msg);
        mismatches++;
    endtask

    // mostly short pauses, a few long ones, now and then a run with none
    function automatic int draw_pause(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(30, 200);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic duty_result_t predict_duty(input lux_sample_t smp);
        logic signed [16:0] err;
        logic signed [17:0] slope;
        logic signed [33:0] wide_sum;
        logic signed [63:0] total;
        logic signed [63:0] drive;
        duty_result_t       res;
        err = $signed({1'b0, smp.target}) - $signed({1'b0, smp.measured});
        wide_sum = err_sum + err + prev_err;
        if (wide_sum > 34'sd2147483647)
            err_sum = 32'sh7FFF_FFFF;
        else if (wide_sum < -34'sd2147483648)
            err_sum = 32'sh8000_0000;
        else
            err_sum = wide_sum[31:0];
        slope = err - prev_err;
        total = kp_q16 * err + ki_q16 * err_sum + kd_q16 * slope;
        drive = total >>> GAIN_FRAC_BITS;   // floor
        prev_err = err;
        if (drive < 0) begin
            res.duty = 16'd0;
            res.clamped = 1'b1;
        end else if (drive > $signed({48'd0, duty_ceiling})) begin
            res.duty = duty_ceiling;
            res.clamped = 1'b1;
        end else begin
            res.duty = drive[15:0];
            res.clamped = 1'b0;
        end
        return res;
    endfunction

    // sample feed
    always @(posedge aclk) begin : sample_feed
        lux_sample_t smp;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left--;
            end else if (lux_samples.size() != 0) begin
                smp = lux_samples.pop_front();
                s_tdata <= smp;
                s_tvalid <= 1'b1;
                gap_left = draw_pause(tx_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(posedge aclk) begin : duty_sink
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                stall_left = draw_pause(rx_calm);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // check outgoing beats first so a result never pairs with this cycle's sample
    always @(posedge aclk) begin : duty_check
        duty_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (predicted_duty.size() == 0) begin
                    report_mismatch($sformatf("duty beat %0d clamped %0b with none pending",
                                              m_tdata, m_tuser[0]));
                end else begin
                    want = predicted_duty.pop_front();
                    if (m_tdata !== want.duty)
                        report_mismatch($sformatf("duty_out got %0d, expected %0d",
                                                  m_tdata, want.duty));
                    if (m_tuser[0] !== want.clamped)
                        report_mismatch($sformatf("clamped got %0b, expected %0b",
                                                  m_tuser[0], want.clamped));
                end
            end
            if (s_tvalid && s_tready) begin
                predicted_duty.push_back(predict_duty(lux_sample_t'(s_tdata)));
                accepted_count++;
            end
        end
    end

    task automatic queue_sample(input int meas, input int targ);
        lux_sample_t smp;
        smp.measured = meas[15:0];
        smp.target = targ[15:0];
        lux_samples.push_back(smp);
        queued_count++;
    endtask

    function automatic lux_sample_t random_sample();
        lux_sample_t smp;
        int          r;
        int          delta;
        r = $urandom_range(0, 99);
        smp.measured = 16'($urandom_range(0, 65535));
        smp.target = smp.measured;
        if (r < 40) begin
            delta = int'($urandom_range(0, 510)) - 255;
            smp.target = smp.measured + delta[15:0];    // wraps near the rails
        end else if (r < 70) begin
            smp.target = 16'($urandom_range(0, 65535));
        end else if (r < 85) begin
            smp.measured = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            smp.target = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        end
        return smp;
    endfunction

    function automatic logic [31:0] pick_gain(input int scale);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r < 3) return $urandom;
        return $urandom_range(0, 2 * scale) - scale;
    endfunction

    function automatic logic [15:0] pick_ceiling();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        if (r < 4) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(200, 8000));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_PROP_GAIN: kp_q16 = value;
            REG_INTG_GAIN: ki_q16 = value;
            REG_DERV_GAIN: kd_q16 = value;
            REG_MAX_DUTY:  duty_ceiling = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] kp, input logic [31:0] ki,
                              input logic [31:0] kd, input logic [15:0] ceiling);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTG_GAIN, ki);
        write_reg(REG_DERV_GAIN, kd);
        write_reg(REG_MAX_DUTY, {16'd0, ceiling});
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // all samples taken, all results back, then the pipeline latency
    task automatic wait_idle();
        int n;
        while (accepted_count != queued_count)
            @(posedge aclk);
        n = 0;
        while (predicted_duty.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        while (predicted_duty.size() != 0) begin
            report_mismatch("expected duty beat never arrived");
            void'(predicted_duty.pop_front());
        end
        repeat (LAT_CYCLES + 2) @(posedge aclk);
    endtask

    task automatic random_phase(input int p);
        if (p == 0)
            set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
        else if (p == 1)
            set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        else
            set_config(pick_gain(1 << 17), pick_gain(64), pick_gain(1 << 17), pick_ceiling());
        repeat (PHASE_BEATS)
            lux_samples.push_back(random_sample());
        queued_count += PHASE_BEATS;
        wait_idle();
    endtask

    initial begin : stimulus
        int p;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset gains: rails, zero error, small errors both ways
        queue_sample(0, 0);
        queue_sample(0, 65535);
        queue_sample(65535, 0);
        queue_sample(1234, 1234);
        queue_sample(500, 520);
        queue_sample(65535, 65535);
        queue_sample(0, 1);
        queue_sample(1, 0);
        wait_idle();

        // Kp = 0.5: drive exactly at ceiling, just over it, and fractional negatives
        set_config(32'h0000_8000, 32'h0, 32'h0, 16'd500);
        queue_sample(0, 0);
        queue_sample(0, 1000);
        queue_sample(0, 1001);
        queue_sample(0, 1002);
        queue_sample(1, 0);
        queue_sample(2, 0);
        queue_sample(100, 100);
        wait_idle();

        // derivative only with a zero ceiling
        set_config(32'h0, 32'h0, 32'h0001_0000, 16'd0);
        queue_sample(0, 0);
        queue_sample(0, 0);
        queue_sample(0, 5);
        queue_sample(0, 5);
        queue_sample(5, 0);
        wait_idle();

        for (p = 0; p < 5; p++)
            random_phase(p);

        // long integral ramps up and back down; Ki of one LSB shows sum >> 16
        set_config(32'h0, 32'h0000_0001, 32'h0, 16'hFFFF);
        repeat (RAMP_BEATS)
            queue_sample($urandom_range(0, 15), $urandom_range(65520, 65535));
        wait_idle();
        set_config(32'h0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF);
        repeat (RAMP_BEATS)
            queue_sample($urandom_range(65520, 65535), $urandom_range(0, 15));
        wait_idle();

        random_phase(5);

        if (mismatches == 0)
            $display("pid_light_regulator_top_test: done, clean");
        else
            $display("pid_light_regulator_top_test: done, errors");
        $finish;
    end

    initial begin : watchdog
        #200ms;
        $display("pid_light_regulator_top_test: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/pidlr_pkg.sv
rtl/core/pid_light_regulator_top.sv
tb/pid_light_regulator_top_test.sv
